[rtl/core/line_pd_steering_assert.svh]
// ----------------------------------------------------------------------------
// line_pd_steering_assert.svh
// Assertion macros for the line PD steering block. Each macro expands to a
// concurrent assertion, or to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_PD_STEERING_ASSERT_SVH
`define LINE_PD_STEERING_ASSERT_SVH

`ifndef SYNTH
// Property checked at every rising edge outside reset.
`define LPS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("line_pd_steering: assertion failed");
// Antecedent in one cycle implies the consequent in the next.
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_pd_steering: assertion failed");
`else
`define LPS_ASSERT(label, clk, rst_n, prop)
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/lps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants of the line PD steering block.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int SENSOR_COUNT_DEF = 32;

    localparam int POS_W   = 14;
    localparam int GAIN_W  = 16;
    localparam int BASE_W  = 15;
    localparam int ERR_W   = 16;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int DRIVE_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Substitute positions for a lost line
    localparam logic [POS_W-1:0] POS_FAR_LEFT  = 14'd0;
    localparam logic [POS_W-1:0] POS_FAR_RIGHT = 14'd15000;
    localparam logic [POS_W-1:0] POS_MIDDLE    = 14'd7000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_POS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DRIVE  = 2'd3;

    // Reset values of the configuration registers
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd256;
    localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd0;
    localparam logic [POS_W-1:0]         CENTER_POS_RST = 14'd7000;
    localparam logic [BASE_W-1:0]        BASE_DRIVE_RST = 15'd0;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic [POS_W-1:0]         center_position;
        logic [BASE_W-1:0]        base_drive;
    } lps_cfg_t;

    // Classified item handed from the front end to the back end
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic [POS_W-1:0]         position_used;
        logic                     dir;
    } lps_item_t;

endpackage

[rtl/core/lps_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_front
// Front end: apply the lost-line fallback, form the error and its change
// and keep the previous error.
// ----------------------------------------------------------------------------
module lps_front #(
    parameter int SENSOR_COUNT = lps_pkg::SENSOR_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lps_pkg::lps_cfg_t           cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lps_pkg::POS_W-1:0]   line_position,
    input  logic [SENSOR_COUNT-1:0]     sensor_bits,
    input  logic                        move_backward,
    output logic                        q_valid,
    input  logic                        q_ready,
    output lps_pkg::lps_item_t          q_item
);
    import lps_pkg::*;

    logic                      left_hit;
    logic                      right_hit;
    logic [POS_W-1:0]          pos_used;
    logic signed [ERR_W-1:0]   err;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [ERR_W-1:0]   prev_err_next;
    logic                      accept;

    assign left_hit  = |sensor_bits[7:0];
    assign right_hit = |sensor_bits[SENSOR_COUNT-1 -: 8];

    always_comb begin
        if (line_position != '0) begin
            pos_used = line_position;
        end else if (left_hit) begin
            pos_used = POS_FAR_LEFT;
        end else if (right_hit) begin
            pos_used = POS_FAR_RIGHT;
        end else begin
            pos_used = POS_MIDDLE;
        end
    end

    // Both operands below 2^14, so the difference fits 16 bits signed
    assign err  = $signed({2'b00, pos_used}) - $signed({2'b00, cfg.center_position});
    assign diff = $signed({err[ERR_W-1], err}) - $signed({prev_err_reg[ERR_W-1], prev_err_reg});

    assign in_ready = q_ready;
    assign q_valid  = in_valid;
    assign accept   = in_valid && q_ready;

    assign q_item.err           = err;
    assign q_item.diff          = diff;
    assign q_item.position_used = pos_used;
    assign q_item.dir           = move_backward;

    assign prev_err_next = accept ? err : prev_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
        end else begin
            prev_err_reg <= prev_err_next;
        end
    end

endmodule

[rtl/core/lps_queue.sv]
`timescale 1ns / 1ps
`include "line_pd_steering_assert.svh"
// ----------------------------------------------------------------------------
// lps_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lps_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  lps_pkg::lps_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output lps_pkg::lps_item_t  out_item
);
    import lps_pkg::*;

    lps_item_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;
    logic        empty_or_full;
    logic        head_waits;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entry_reg[rd_ptr_reg];

    assign empty_or_full = (count_reg == 2'd0 || count_reg == 2'd2);
    assign head_waits    = out_valid && !out_ready && count_reg == 2'd1;

    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Fill level and pointers agree: equal pointers mean empty or full
    `LPS_ASSERT(a_ptr_count, aclk, aresetn, (wr_ptr_reg == rd_ptr_reg) == empty_or_full)
    `LPS_ASSERT_NEXT(a_push_grows, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 2'd1)
    `LPS_ASSERT_NEXT(a_head_holds, aclk, aresetn, head_waits, out_valid && $stable(rd_ptr_reg))

endmodule

[rtl/core/lps_back.sv]
`timescale 1ns / 1ps
`include "line_pd_steering_assert.svh"
// ----------------------------------------------------------------------------
// lps_back
// Back end: gain products, correction with truncation and saturation,
// then motor drives into the output register.
// ----------------------------------------------------------------------------
module lps_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lps_pkg::lps_cfg_t             cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lps_pkg::lps_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lps_pkg::DRIVE_W-1:0]   left_drive,
    output logic [lps_pkg::DRIVE_W-1:0]   right_drive,
    output logic [lps_pkg::POS_W-1:0]     position_used,
    output logic                          dir_out
);
    import lps_pkg::*;

    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int DP_W  = GAIN_W + DIFF_W;
    localparam int ACC_W = DP_W + 1;

    // Stage 1: products
    logic                      v1_reg;
    logic signed [PP_W-1:0]    pp_reg;
    logic signed [DP_W-1:0]    dp_reg;
    logic [POS_W-1:0]          pos1_reg;
    logic                      dir1_reg;
    // Stage 2: correction
    logic                      v2_reg;
    logic signed [DRIVE_W-1:0] corr_reg;
    logic [POS_W-1:0]          pos2_reg;
    logic                      dir2_reg;
    // Stage 3: output register
    logic                      v3_reg;
    logic [DRIVE_W-1:0]        left_reg;
    logic [DRIVE_W-1:0]        right_reg;
    logic [POS_W-1:0]          pos3_reg;
    logic                      dir3_reg;

    logic                      adv1;
    logic                      adv2;
    logic                      adv3;
    logic                      v1_next;
    logic                      v2_next;
    logic                      v3_next;

    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_biased;
    logic signed [ACC_W-1:0]   quot;
    logic signed [DRIVE_W-1:0] corr_next;
    logic signed [DRIVE_W:0]   sum_drive;
    logic signed [DRIVE_W:0]   dif_drive;
    logic [DRIVE_W-1:0]        sum_sat;
    logic [DRIVE_W-1:0]        dif_sat;

    function automatic logic [BASE_W-1:0] pos_base(input logic [BASE_W-1:0] b);
        return b;
    endfunction

    function automatic logic [DRIVE_W-1:0] sat_drive(input logic signed [DRIVE_W:0] v);
        logic [DRIVE_W-1:0] r;
        if (v[DRIVE_W] != v[DRIVE_W-1]) begin
            r = v[DRIVE_W] ? 16'h8000 : 16'h7FFF;
        end else begin
            r = v[DRIVE_W-1:0];
        end
        return r;
    endfunction

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign v1_next = adv1 ? in_valid : v1_reg;
    assign v2_next = adv2 ? v1_reg : v2_reg;
    assign v3_next = adv3 ? v2_reg : v3_reg;

    // Truncate toward zero: bias negative sums by 255 before the shift
    assign acc = $signed({{(ACC_W-PP_W){pp_reg[PP_W-1]}}, pp_reg})
               + $signed({dp_reg[DP_W-1], dp_reg});
    assign acc_biased = acc[ACC_W-1] ? (acc + $signed(ACC_W'(255))) : acc;
    assign quot = acc_biased >>> 8;

    always_comb begin
        if (quot > $signed(ACC_W'(32767))) begin
            corr_next = 16'sh7FFF;
        end else if (quot < -$signed(ACC_W'(32768))) begin
            corr_next = 16'sh8000;
        end else begin
            corr_next = quot[DRIVE_W-1:0];
        end
    end

    assign sum_drive = $signed({2'b00, pos_base(cfg.base_drive)})
                     + $signed({corr_reg[DRIVE_W-1], corr_reg});
    assign dif_drive = $signed({2'b00, pos_base(cfg.base_drive)})
                     - $signed({corr_reg[DRIVE_W-1], corr_reg});

    assign sum_sat = sat_drive(sum_drive);
    assign dif_sat = sat_drive(dif_drive);

    always_ff @(posedge aclk) begin
        if (adv1) begin
            pp_reg   <= PP_W'(cfg.prop_gain) * PP_W'(in_item.err);
            dp_reg   <= DP_W'(cfg.deriv_gain) * DP_W'(in_item.diff);
            pos1_reg <= in_item.position_used;
            dir1_reg <= in_item.dir;
        end
        if (adv2) begin
            corr_reg <= corr_next;
            pos2_reg <= pos1_reg;
            dir2_reg <= dir1_reg;
        end
        if (adv3) begin
            left_reg  <= dir2_reg ? dif_sat : sum_sat;
            right_reg <= dir2_reg ? sum_sat : dif_sat;
            pos3_reg  <= pos2_reg;
            dir3_reg  <= dir2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign out_valid     = v3_reg;
    assign left_drive    = left_reg;
    assign right_drive   = right_reg;
    assign position_used = pos3_reg;
    assign dir_out       = dir3_reg;

    // A full pipe with a stalled receiver must refuse the queue
    `LPS_ASSERT(a_full_stall, aclk, aresetn, !(v1_reg && v2_reg && v3_reg && !out_ready) || !in_ready)
    // A stalled product stage keeps its item
    `LPS_ASSERT_NEXT(a_s1_hold, aclk, aresetn, v1_reg && !adv2, v1_reg && $stable(pp_reg) && $stable(dp_reg))

endmodule

[rtl/core/line_pd_steering.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pd_steering
// PD steering for a line follower: sensor sample in, motor drives out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item per sensor sample (line position, sensor
//   detect bits, direction). Result channel m_*: one item per sample with
//   left and right drive, the position actually used and the direction.
//   Configuration: cfg_wr_en/cfg_index/cfg_wdata write gains, centre and
//   base drive; write only while no item is in flight.
//   Path: an accepted item passes the queue, product stage, correction
//   stage and output register before it shows on m_tvalid.
//   Throughput: one item per cycle while m_tready is high, set by the single
//   product stage and pipelined back end; the previous error updates on each accept.
//   Reset (aresetn low at an edge): registers return to defaults, previous
//   error clears, queue and pipeline empty.
//   Receiver stall: the output register holds; the back end fills, then the
//   two-entry queue, and only then does s_tready drop.
// ----------------------------------------------------------------------------
module line_pd_steering #(
    parameter int SENSOR_COUNT = lps_pkg::SENSOR_COUNT_DEF,
    localparam int IN_DATA_W   = ((lps_pkg::POS_W + SENSOR_COUNT + 1 + 7) / 8) * 8,
    localparam int OUT_DATA_W  = ((2 * lps_pkg::DRIVE_W + lps_pkg::POS_W + 1 + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port
    input  logic                          cfg_wr_en,
    input  logic [lps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lps_pkg::CFG_W-1:0]     cfg_wdata,
    // Input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata from bit 0: line_position[13:0], sensor_bits, move_backward, zero pad
    input  logic [IN_DATA_W-1:0]          s_tdata,
    // Result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata from bit 0: left_drive, right_drive, position_used, dir_out, zero pad
    output logic [OUT_DATA_W-1:0]         m_tdata
);
    import lps_pkg::*;

    localparam int DIR_BIT = POS_W + SENSOR_COUNT;

    // Configuration registers
    logic signed [GAIN_W-1:0] prop_gain_reg;
    logic signed [GAIN_W-1:0] deriv_gain_reg;
    logic [POS_W-1:0]         center_reg;
    logic [BASE_W-1:0]        base_reg;
    lps_cfg_t                 cfg;

    logic                     q_in_valid;
    logic                     q_in_ready;
    lps_item_t                q_in_item;
    logic                     q_out_valid;
    logic                     q_out_ready;
    lps_item_t                q_out_item;

    logic [DRIVE_W-1:0]       left_drive;
    logic [DRIVE_W-1:0]       right_drive;
    logic [POS_W-1:0]         position_used;
    logic                     dir_out;

    // Take register writes; indexes outside the list do not exist with this width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= PROP_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            center_reg     <= CENTER_POS_RST;
            base_reg       <= BASE_DRIVE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_wdata;
                REG_DERIV_GAIN: deriv_gain_reg <= cfg_wdata;
                REG_CENTER_POS: center_reg     <= cfg_wdata[POS_W-1:0];
                REG_BASE_DRIVE: base_reg       <= cfg_wdata[BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.prop_gain       = prop_gain_reg;
    assign cfg.deriv_gain      = deriv_gain_reg;
    assign cfg.center_position = center_reg;
    assign cfg.base_drive      = base_reg;

    // Front end: classify the sample and form error terms
    lps_front #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .line_position (s_tdata[POS_W-1:0]),
        .sensor_bits   (s_tdata[POS_W +: SENSOR_COUNT]),
        .move_backward (s_tdata[DIR_BIT]),
        .q_valid       (q_in_valid),
        .q_ready       (q_in_ready),
        .q_item        (q_in_item)
    );

    // Decouple front and back so each may stall on its own
    lps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_item   (q_in_item),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_item  (q_out_item)
    );

    // Back end: gains, correction and drives
    lps_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .in_valid      (q_out_valid),
        .in_ready      (q_out_ready),
        .in_item       (q_out_item),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .left_drive    (left_drive),
        .right_drive   (right_drive),
        .position_used (position_used),
        .dir_out       (dir_out)
    );

    // Pack the result, pad to whole bytes with zeros
    assign m_tdata = OUT_DATA_W'({dir_out, position_used, right_drive, left_drive});

endmodule
